>>> rtl/core/apl_pkg.sv
// ----------------------------------------------------------------------------
// apl_pkg
// Shared widths, codes and types of the audio peak level meter.
// ----------------------------------------------------------------------------
package apl_pkg;

  // Field widths.
  localparam int SAMPLE_W    = 32;
  localparam int PEAK_W      = 32;
  localparam int LEVEL_W     = 17;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int FORMAT_W    = 3;

  // Default number of fraction bits in the level.
  localparam int DEF_LEVEL_FRACTION_BITS = 16;

  // Bits the float shifter moves per cycle.
  localparam int FLT_DIGIT = 4;

  // Width of the float product, mantissa times 2^31-1.
  localparam int FLT_PROD_W = 55;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SAMPLE_FORMAT = 1'b0;
  localparam logic REG_BIG_ENDIAN    = 1'b1;

  // Sample format codes.
  localparam logic [FORMAT_W-1:0] FMT_U8  = 3'd0;
  localparam logic [FORMAT_W-1:0] FMT_S8  = 3'd1;
  localparam logic [FORMAT_W-1:0] FMT_U16 = 3'd2;
  localparam logic [FORMAT_W-1:0] FMT_S16 = 3'd3;
  localparam logic [FORMAT_W-1:0] FMT_U32 = 3'd4;
  localparam logic [FORMAT_W-1:0] FMT_S32 = 3'd5;
  localparam logic [FORMAT_W-1:0] FMT_F32 = 3'd6;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLOAT,
    ST_DIV
  } apl_state_t;

endpackage

>>> rtl/core/apl_float_mag.sv
// ----------------------------------------------------------------------------
// apl_float_mag
// Turns an IEEE single into |f| * (2^31-1), truncated and saturated at
// 2^32-1. The scaled mantissa is shifted right a few bits per cycle.
// ----------------------------------------------------------------------------
module apl_float_mag
  import apl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] word,
  output logic                done,
  output logic [PEAK_W-1:0]   mag
);

  localparam int CNT_W = $clog2(FLT_PROD_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [FLT_PROD_W-1:0] prod;

  logic [7:0]            exp_raw;
  logic [7:0]            exp_eff;
  logic [23:0]           mant;
  logic [7:0]            shift_amt;
  logic                  is_sat;
  logic                  is_zero;
  logic [FLT_PROD_W-1:0] prod_init;

  // Unpack the word and sort out the special cases.
  always_comb begin
    exp_raw   = word[30:23];
    exp_eff   = (exp_raw == 8'd0) ? 8'd1 : exp_raw;
    mant      = {(exp_raw != 8'd0), word[22:0]};
    shift_amt = 8'd150 - exp_eff;
    is_sat    = (exp_raw == 8'hFF) || ((mant != 24'd0) && (exp_eff >= 8'd150));
    is_zero   = (mant == 24'd0) || (shift_amt >= 8'(FLT_PROD_W + 1));
    // m * (2^31 - 1) = (m << 31) - m
    prod_init = {mant, 31'd0} - {31'd0, mant};
  end

  // Shift register steps down by one digit per cycle, the tail by less.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      if (is_sat) begin
        prod <= '1;
        cnt  <= '0;
      end else if (is_zero) begin
        prod <= '0;
        cnt  <= '0;
      end else begin
        prod <= prod_init;
        cnt  <= CNT_W'(shift_amt);
      end
    end else if (busy) begin
      if (cnt >= CNT_W'(FLT_DIGIT)) begin
        prod <= prod >> FLT_DIGIT;
        cnt  <= cnt - CNT_W'(FLT_DIGIT);
      end else if (cnt != '0) begin
        prod <= prod >> cnt;
        cnt  <= '0;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // Result is ready once the whole shift has been applied.
  assign done = busy && (cnt == '0);
  assign mag  = (prod[FLT_PROD_W-1:PEAK_W] != '0) ? '1 : prod[PEAK_W-1:0];

endmodule

>>> rtl/core/apl_divider.sv
// ----------------------------------------------------------------------------
// apl_divider
// Bit-serial restoring divider for (num << FRAC) / den with num <= den.
// One quotient bit is produced per cycle.
// ----------------------------------------------------------------------------
module apl_divider
  import apl_pkg::*;
#(
  parameter int FRAC = DEF_LEVEL_FRACTION_BITS
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PEAK_W-1:0] num,
  input  logic [PEAK_W-1:0] den,
  output logic              busy,
  output logic [FRAC:0]     quo
);

  localparam int STEPS = FRAC + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]  cnt;
  logic [PEAK_W-1:0] rem;
  logic [PEAK_W-1:0] divisor;
  logic [PEAK_W:0]   trial;
  logic              ge;

  // The first step compares the numerator itself; later steps shift first.
  always_comb begin
    trial = (cnt == CNT_W'(STEPS)) ? {1'b0, rem} : {rem, 1'b0};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt     <= CNT_W'(STEPS);
      rem     <= num;
      divisor <= den;
      quo     <= '0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      rem <= ge ? PEAK_W'(trial - {1'b0, divisor}) : PEAK_W'(trial);
      quo <= {quo[FRAC-1:0], ge};
    end
  end

  assign busy = (cnt != '0);

endmodule

>>> rtl/core/audio_peak_level_meter.sv
// ----------------------------------------------------------------------------
// audio_peak_level_meter
// Decodes raw samples by format and byte order, tracks the peak magnitude
// over a buffer and, on the last word of a buffer, gives the clamped peak
// and peak / full scale as an unsigned fixed-point level.
//
//   Channel  Dir  Handshake              Contents
//   s_*      in   s_tvalid / s_tready    tdata: sample_word; tlast: last_of_buffer
//   m_*      out  m_tvalid / m_tready    tdata: level_q16, peak_value
//   APB      in   psel & penable         0x0 sample_format, 0x4 big_endian
//
// Integer samples are taken while the sequencer is idle. A float sample holds
// off the input until the float shifter, moving 4 bits a cycle over
// 150 - exponent bits, is done. The last word of a buffer also holds the input
// while the serial divider runs and while the output register waits for m_tready.
// Reset restores sample_format 3, little-endian and a zero peak at once.
// ----------------------------------------------------------------------------
module audio_peak_level_meter
  import apl_pkg::*;
#(
  parameter int LEVEL_FRACTION_BITS = DEF_LEVEL_FRACTION_BITS
)
(
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] sample_word
  input  logic                   s_tlast,
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [16:0] level_q16, [48:17] peak_value
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // Helpers for byte order and full scale.
  function automatic logic [15:0] swap16(input logic [31:0] w);
    return {w[7:0], w[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [PEAK_W-1:0] full_scale(input logic [FORMAT_W-1:0] fmt);
    case (fmt)
      FMT_U8:  return 32'd255;
      FMT_S8:  return 32'd127;
      FMT_U16: return 32'd65535;
      FMT_S16: return 32'd32767;
      FMT_U32: return 32'hFFFF_FFFF;
      FMT_S32: return 32'h7FFF_FFFF;
      FMT_F32: return 32'h7FFF_FFFF;
      default: return '0;
    endcase
  endfunction

  // Configuration registers.
  logic [FORMAT_W-1:0] sample_format;
  logic                big_endian;
  logic                cfg_write;
  logic                cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_S16;
      big_endian    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLE_FORMAT: sample_format <= pwdata[FORMAT_W-1:0];
        REG_BIG_ENDIAN:    big_endian    <= pwdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_SAMPLE_FORMAT: prdata = {{(CFG_DATA_W-FORMAT_W){1'b0}}, sample_format};
      REG_BIG_ENDIAN:    prdata = {{(CFG_DATA_W-1){1'b0}}, big_endian};
      default:           prdata = '0;
    endcase
  end

  // Integer decode of the incoming word.
  logic [15:0]       word16;
  logic [31:0]       word32;
  logic [PEAK_W-1:0] int_mag;
  logic              is_float;
  logic [PEAK_W-1:0] fs;

  always_comb begin
    word16   = big_endian ? swap16(s_tdata) : s_tdata[15:0];
    word32   = big_endian ? swap32(s_tdata) : s_tdata;
    is_float = (sample_format == FMT_F32);
    fs       = full_scale(sample_format);
    case (sample_format)
      FMT_U8:  int_mag = 32'(s_tdata[7:0]);
      FMT_S8:  int_mag = s_tdata[7] ? 32'(9'h100 - {1'b0, s_tdata[7:0]})
                                    : 32'(s_tdata[7:0]);
      FMT_U16: int_mag = 32'(word16);
      FMT_S16: int_mag = word16[15] ? 32'(17'h10000 - {1'b0, word16})
                                    : 32'(word16);
      FMT_U32: int_mag = word32;
      FMT_S32: int_mag = word32[31] ? (32'd0 - word32) : word32;
      default: int_mag = '0;
    endcase
  end

  // Serial float magnitude unit.
  logic              flt_start;
  logic              flt_done;
  logic [PEAK_W-1:0] flt_mag;

  apl_float_mag u_float (
    .clk   (clk),
    .rst   (rst),
    .start (flt_start),
    .word  (word32),
    .done  (flt_done),
    .mag   (flt_mag)
  );

  // Serial divider for the level.
  logic                       div_start;
  logic                       div_busy;
  logic [LEVEL_FRACTION_BITS:0] div_quo;
  logic [PEAK_W-1:0]          peak_hold;
  logic [PEAK_W-1:0]          peak_clamp;

  apl_divider #(
    .FRAC (LEVEL_FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (peak_clamp),
    .den   (fs),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // Sequencer: next state, peak update and output load.
  apl_state_t        state;
  apl_state_t        state_next;
  logic [PEAK_W-1:0] running_peak;
  logic [PEAK_W-1:0] running_peak_next;
  logic              last_hold;
  logic              in_accept;
  logic              mag_valid;
  logic [PEAK_W-1:0] cand_mag;
  logic              cand_last;
  logic [PEAK_W-1:0] peak_max;
  logic              out_load;

  always_comb begin
    s_tready          = (state == ST_IDLE);
    in_accept         = s_tvalid && s_tready;
    flt_start         = in_accept && is_float;
    mag_valid         = (in_accept && !is_float) || ((state == ST_FLOAT) && flt_done);
    cand_mag          = (state == ST_FLOAT) ? flt_mag : int_mag;
    cand_last         = (state == ST_FLOAT) ? last_hold : s_tlast;
    peak_max          = (cand_mag > running_peak) ? cand_mag : running_peak;
    peak_clamp        = (peak_max > fs) ? fs : peak_max;
    state_next        = state;
    running_peak_next = running_peak;
    div_start         = 1'b0;
    out_load          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (flt_start) begin
          state_next = ST_FLOAT;
        end
      end
      ST_FLOAT: begin
        state_next = ST_FLOAT;
      end
      ST_DIV: begin
        if (!div_busy && (!m_tvalid || m_tready)) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // A decoded magnitude either updates the peak or closes the buffer.
    if (mag_valid) begin
      if (cand_last) begin
        running_peak_next = '0;
        if (fs != '0) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end else begin
        running_peak_next = peak_max;
        state_next        = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_peak <= '0;
    end else begin
      state        <= state_next;
      running_peak <= running_peak_next;
    end
  end

  // Payload holding registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      last_hold <= s_tlast;
    end
    if (div_start) begin
      peak_hold <= peak_clamp;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OUT_TDATA_W-PEAK_W-LEVEL_W){1'b0}}, peak_hold, LEVEL_W'(div_quo)};
    end
  end

endmodule
